[rtl/cpd_pkg.sv]
`timescale 1ns / 1ps
// cpd_pkg: types and constants for the CRC-16 packet deframer.
// No dependencies; imported by every module of the block.
package cpd_pkg;

  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcTop        = 16'h8000;
  localparam logic [15:0] PolyReset     = 16'h1021;
  localparam logic [7:0]  MinFrameBytes = 8'd5;
  localparam logic [7:0]  PosMax        = 8'd255;
  localparam logic [7:0]  HdrBytes      = 8'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } in_req_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_id;
    logic [7:0] frame_type;
    logic [7:0] payload_length;
    logic       frame_ok;
  } out_req_t;

endpackage

[rtl/cpd_crc_byte.sv]
`timescale 1ns / 1ps
// cpd_crc_byte: one-byte MSB-first CRC-16 update, unrolled over eight bits.
// Depends on cpd_pkg.
module cpd_crc_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  input  logic [15:0] poly_i,
  output logic [15:0] crc_o
);
  import cpd_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {byte_i, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTop) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ poly_i;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

[rtl/cpd_frame_track.sv]
`timescale 1ns / 1ps
// cpd_frame_track: per-frame state (position, CRC, header bytes) and result build.
// Depends on cpd_pkg and cpd_crc_byte.
module cpd_frame_track (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  cpd_pkg::in_req_t    req_i,
  input  logic [15:0]         poly_i,
  output logic                res_valid_o,
  output cpd_pkg::out_req_t   res_o
);
  import cpd_pkg::*;

  logic [7:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  crch_q, crch_d;

  logic [7:0]  b;
  logic        eof;
  logic [7:0]  cur_len, cur_id, cur_type, cur_crch, plen;
  logic [15:0] crc_next;
  logic        ok, in_payload;

  assign b   = req_i.rx_byte;
  assign eof = req_i.end_of_frame;

  cpd_crc_byte u_crc (
    .crc_i  (crc_q),
    .byte_i (b),
    .poly_i (poly_i),
    .crc_o  (crc_next)
  );

  always_comb begin
    // position 0 carries the length and starts a fresh header
    cur_len  = (pos_q == 8'd0) ? b : len_q;
    cur_id   = (pos_q == 8'd0) ? 8'd0 : ((pos_q == 8'd1) ? b : id_q);
    cur_type = (pos_q == 8'd0) ? 8'd0 : ((pos_q == 8'd2) ? b : type_q);
    cur_crch = (pos_q == 8'd0) ? 8'd0 : crch_q;
    plen     = (cur_len >= HdrBytes) ? cur_len - HdrBytes : 8'd0;

    ok = (pos_q != PosMax) && ({1'b0, pos_q} == {1'b0, cur_len} + 9'd1) &&
         (pos_q >= MinFrameBytes - 8'd1) && (crc_q == {cur_crch, b});
    in_payload = (pos_q >= HdrBytes) && (pos_q < cur_len);

    res_valid_o          = eof || in_payload;
    res_o.is_status      = eof;
    res_o.payload_byte   = eof ? 8'd0 : b;
    res_o.payload_index  = eof ? 8'd0 : pos_q - HdrBytes;
    res_o.frame_id       = cur_id;
    res_o.frame_type     = cur_type;
    res_o.payload_length = plen;
    res_o.frame_ok       = eof && ok;
  end

  always_comb begin
    pos_d  = pos_q;
    crc_d  = crc_q;
    len_d  = len_q;
    id_d   = id_q;
    type_d = type_q;
    crch_d = crch_q;
    if (take_i) begin
      if (eof) begin
        pos_d  = 8'd0;
        crc_d  = CrcInit;
        len_d  = 8'd0;
        id_d   = 8'd0;
        type_d = 8'd0;
        crch_d = 8'd0;
      end else begin
        len_d  = cur_len;
        id_d   = cur_id;
        type_d = cur_type;
        crch_d = (pos_q == cur_len) ? b : cur_crch;
        if (pos_q < cur_len) crc_d = crc_next;
        if (pos_q != PosMax) pos_d = pos_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 8'd0;
      crc_q  <= CrcInit;
      len_q  <= 8'd0;
      id_q   <= 8'd0;
      type_q <= 8'd0;
      crch_q <= 8'd0;
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      len_q  <= len_d;
      id_q   <= id_d;
      type_q <= type_d;
      crch_q <= crch_d;
    end
  end

endmodule

[rtl/crc16_packet_deframer_core.sv]
`timescale 1ns / 1ps
// crc16_packet_deframer_core: top level of the length-prefixed CRC-16 deframer.
// Depends on cpd_pkg, cpd_frame_track and cpd_crc_byte.
//
// Takes one received byte per request and, for a frame laid out as
// length L, id, type, L-3 payload bytes and a big-endian CRC-16 over the
// first L bytes (init 0xFFFF, MSB first, polynomial from the config
// register, reset 0x1021), emits each payload byte as it arrives and one
// status request on the byte flagged end_of_frame. frame_ok is set only
// when at least 5 bytes arrived, the count is L+2 and the CRC matches.
// Throughput is one byte per clock while the output is not stalled: frame state
// updates in the same cycle the byte is accepted, and the result lands in a single
// output register on the following cycle. The critical path is the unrolled eight-bit
// CRC step feeding the running CRC register. The input side stays ready
// while the output register is empty or being drained this cycle, so a
// stall downstream holds off input only while the output register is full.
// The polynomial register is always ready; write it only while idle.
module crc16_packet_deframer_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cpd_pkg::in_req_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cpd_pkg::out_req_t  out_data_o
);
  import cpd_pkg::*;

  logic [15:0] poly_q;
  logic        take;
  logic        res_valid;
  out_req_t    res;
  logic        out_valid_q, out_valid_d;
  out_req_t    out_data_q;

  assign cfg_ready_o = 1'b1;
  // output slot free, or being emptied this cycle
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign take        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= PolyReset;
    end else if (cfg_valid_i) begin
      poly_q <= cfg_data_i;
    end
  end

  cpd_frame_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .req_i       (in_data_i),
    .poly_i      (poly_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, loaded only with a real result
  always_ff @(posedge clk_i) begin
    if (take && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/cpd_checker.sv]
`timescale 1ns / 1ps
// cpd_checker: port-level assertions for crc16_packet_deframer_core.
// Depends on cpd_pkg; bound to the top level at the end of this file.
module cpd_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_ready_o,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  cpd_pkg::out_req_t  out_data_o
);
  import cpd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output request dropped or changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input held off with an empty output register");

  a_payload_not_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_status |-> !out_data_o.frame_ok)
    else $error("payload request carries frame_ok");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_status |->
      out_data_o.payload_byte == 8'd0 && out_data_o.payload_index == 8'd0)
    else $error("status request with non-zero payload fields");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_status |->
      out_data_o.payload_index < out_data_o.payload_length)
    else $error("payload index beyond declared length");

endmodule

bind crc16_packet_deframer_core cpd_checker u_cpd_checker (.*);

[sim/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for crc16_packet_deframer_core.
// Depends on cpd_pkg and the deframer RTL; builds CRC-16 frames and predicts every result.
module testbench;
  import cpd_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int MaxWait    = 17;
  localparam int PhaseBytes = 180;

  typedef enum {FrGood, FrBadCrc, FrCut, FrPadded} frame_kind_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_req_t    in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_req_t   out_data_o;

  crc16_packet_deframer_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // deframer shadow state
  logic [15:0] dfr_poly;
  int          dfr_pos;
  logic [15:0] dfr_crc;
  logic [7:0]  dfr_len;
  logic [7:0]  dfr_id;
  logic [7:0]  dfr_type;
  logic [7:0]  dfr_crc_hi;

  out_req_t   frame_results_q[$];
  logic [7:0] frame_buf[$];

  bit tx_idle       = 1'b1;
  bit rx_idle       = 1'b1;
  int rx_hold_cycles = 0;
  int cycle_count   = 0;
  int bytes_sent    = 0;
  int frames_sent   = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int polys_written = 0;

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b,
                                             logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  task automatic clear_frame_state();
    dfr_pos    = 0;
    dfr_crc    = CrcInit;
    dfr_len    = '0;
    dfr_id     = '0;
    dfr_type   = '0;
    dfr_crc_hi = '0;
  endtask

  // Works out what one accepted byte produces and queues it.
  task automatic deframe_byte(input logic [7:0] b, input logic eof);
    out_req_t    r;
    int          pos;
    int          plen;
    logic [15:0] rx_crc;
    pos = dfr_pos;
    if (pos == 0) begin
      dfr_len    = b;
      dfr_id     = '0;
      dfr_type   = '0;
      dfr_crc_hi = '0;
    end else if (pos == 1) begin
      dfr_id = b;
    end else if (pos == 2) begin
      dfr_type = b;
    end
    plen             = (dfr_len >= HdrBytes) ? int'(dfr_len) - int'(HdrBytes) : 0;
    r                = '0;
    r.frame_id       = dfr_id;
    r.frame_type     = dfr_type;
    r.payload_length = 8'(plen);
    if (eof) begin
      rx_crc      = {dfr_crc_hi, b};
      r.is_status = 1'b1;
      r.frame_ok  = (pos < int'(PosMax)) && (pos == int'(dfr_len) + 1) &&
                    (pos + 1 >= int'(MinFrameBytes)) && (dfr_crc == rx_crc);
      frame_results_q.push_back(r);
      clear_frame_state();
    end else begin
      if (pos < int'(dfr_len)) dfr_crc = crc16_step(dfr_crc, b, dfr_poly);
      if (pos == int'(dfr_len)) dfr_crc_hi = b;
      if (pos < int'(PosMax)) dfr_pos = pos + 1;
      if (pos >= int'(HdrBytes) && pos < int'(dfr_len)) begin
        r.payload_byte  = b;
        r.payload_index = 8'(pos - int'(HdrBytes));
        frame_results_q.push_back(r);
      end
    end
  endtask

  // Offers one byte and holds it until taken; valid stays high for a back-to-back byte.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = tx_idle ? $urandom_range(0, MaxWait) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{rx_byte: b, end_of_frame: eof};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    deframe_byte(b, eof);
    bytes_sent++;
  endtask

  // Input quiet, all results back, then a settling wait for the last byte.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_poly(input logic [15:0] poly);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= poly;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    dfr_poly = poly;
    polys_written++;
  endtask

  // Fills frame_buf: length, id, type, payload, CRC, then the chosen fault.
  task automatic build_frame(input int len, input frame_kind_e kind, input int pad);
    logic [15:0] crc;
    int          cut;
    int          idx;
    frame_buf.delete();
    frame_buf.push_back(8'(len));
    for (int i = 1; i < len; i++) frame_buf.push_back(8'($urandom));
    crc = CrcInit;
    for (int i = 0; i < len; i++) crc = crc16_step(crc, frame_buf[i], dfr_poly);
    frame_buf.push_back(crc[15:8]);
    frame_buf.push_back(crc[7:0]);
    case (kind)
      FrBadCrc: begin
        idx = frame_buf.size() - 1 - $urandom_range(0, 1);
        frame_buf[idx] = frame_buf[idx] ^ 8'(1 << $urandom_range(0, 7));
      end
      FrCut: begin
        cut = $urandom_range(1, frame_buf.size() - 1);
        while (frame_buf.size() > cut) void'(frame_buf.pop_back());
      end
      FrPadded: begin
        repeat (pad) frame_buf.push_back(8'($urandom));
      end
      default: ;
    endcase
  endtask

  task automatic send_frame(input int len, input frame_kind_e kind, input int pad = 2);
    build_frame(len, kind, pad);
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
    frames_sent++;
  endtask

  // Junk bytes with stray end marks, always closed by one.
  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_byte(8'($urandom), (i == count - 1) || ($urandom_range(0, 5) == 0));
    end
  endtask

  task automatic send_random_frame();
    int len;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) len = $urandom_range(0, 2);
    else if (pick < 9) len = $urandom_range(25, 253);
    else len = $urandom_range(3, 24);
    pick = $urandom_range(0, 99);
    if (pick < 75) send_frame(len, FrGood);
    else if (pick < 83) send_frame(len, FrBadCrc);
    else if (pick < 90) send_frame(len, FrCut);
    else if (pick < 95) send_frame(len, FrPadded, $urandom_range(1, 3));
    else send_noise($urandom_range(1, 8));
  endtask

  task automatic report_mismatch(input string what, input out_req_t want,
                                 input out_req_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at %0t: expected st=%0d byte=%02h idx=%0d id=%02h type=%02h len=%0d ok=%0d",
               what, $time, want.is_status, want.payload_byte, want.payload_index,
               want.frame_id, want.frame_type, want.payload_length, want.frame_ok);
      $display("  got st=%0d byte=%02h idx=%0d id=%02h type=%02h len=%0d ok=%0d",
               got.is_status, got.payload_byte, got.payload_index, got.frame_id,
               got.frame_type, got.payload_length, got.frame_ok);
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Short frames at reset polynomial: minimum frame, end mark on length byte,
  // too short with good CRC, bad CRC, bytes past the CRC, cut frame.
  task automatic test_directed();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_frame(3, FrGood);
    send_frame(4, FrGood);
    send_byte(8'hFF, 1'b1);
    send_frame(2, FrGood);
    send_frame(3, FrBadCrc);
    send_frame(3, FrPadded, 1);
    send_frame(6, FrCut);
  endtask

  task automatic test_random_polys();
    logic [15:0] polys[5];
    int          stop_at;
    polys[0] = 16'h0000;
    polys[1] = 16'hFFFF;
    polys[2] = 16'h8005;
    polys[3] = 16'($urandom);
    polys[4] = PolyReset;
    for (int p = 0; p < 5; p++) begin
      write_poly(polys[p]);
      tx_idle = (p != 2);
      rx_idle = (p != 2) && (p != 4);
      stop_at = bytes_sent + PhaseBytes;
      while (bytes_sent < stop_at) send_random_frame();
    end
  endtask

  // Longest frame that can pass, one that cannot, and a frame run past saturation.
  task automatic test_long_frames();
    wait_idle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_frame(253, FrGood);
    send_frame(254, FrGood);
    send_frame(10, FrPadded, 250);
  endtask

  // Receiver holds off while the sender streams, then the sender waits for a full drain.
  task automatic test_backpressure();
    wait_idle();
    tx_idle        = 1'b0;
    rx_idle        = 1'b0;
    rx_hold_cycles = 200;
    send_frame(60, FrGood);
    wait_idle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_frame(20, FrGood);
  endtask

  // ------------------------------------------------------------ processes

  initial begin : result_taker
    int stall;
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        while (rx_hold_cycles > 0) begin
          @(posedge clk_i);
          rx_hold_cycles--;
        end
      end
      stall = rx_idle ? $urandom_range(0, MaxWait) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o && rx_hold_cycles == 0) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    out_req_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_results_q.size() == 0) begin
        report_mismatch("unexpected result", '0, out_data_o);
      end else begin
        want = frame_results_q.pop_front();
        results_seen++;
        if (out_data_o.is_status      !== want.is_status      ||
            out_data_o.payload_byte   !== want.payload_byte   ||
            out_data_o.payload_index  !== want.payload_index  ||
            out_data_o.frame_id       !== want.frame_id       ||
            out_data_o.frame_type     !== want.frame_type     ||
            out_data_o.payload_length !== want.payload_length ||
            out_data_o.frame_ok       !== want.frame_ok) begin
          report_mismatch("mismatch", want, out_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, frame_results_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    dfr_poly = PolyReset;
    clear_frame_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_polys();
    test_long_frames();
    test_backpressure();

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d results from %0d bytes in %0d frames, %0d polynomial writes,",
             results_seen, bytes_sent, frames_sent, polys_written);
    $display("covering faulty, cut, padded and overlong frames and a long output stall.");
    if (mismatches == 0 && frame_results_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
